[rtl/rfsa_pkg.sv]
// ----------------------------------------------------------------------------
// rfsa_pkg
// Shared types and constants of the family size and ages sampler: field
// widths, operation and result codes, register map and pipeline item types.
// ----------------------------------------------------------------------------
package rfsa_pkg;

	// field widths
	localparam int WORD_W     = 16;
	localparam int PROB_W     = 16;
	localparam int NUM_PROBS  = 16;
	localparam int SUM_W      = 20;
	localparam int COUNT_W    = 4;
	localparam int AGE_W      = 6;
	localparam int ENT_W      = 5;
	localparam int N_W        = 7;
	localparam int MUL_W      = WORD_W + N_W;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// operation codes of an input item
	localparam logic OP_TOSS = 1'b0;
	localparam logic OP_PICK = 1'b1;

	// result kinds
	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_AGE   = 1'b1;

	// register map, one register every eight bytes
	typedef enum logic [2:0] {
		REG_PROB0,
		REG_PROB1,
		REG_PROB2,
		REG_PROB3,
		REG_ENTRIES,
		REG_FIRST_AGE,
		REG_LAST_AGE
	} reg_idx_t;

	// how ages are spread over a family
	typedef enum logic [1:0] {
		MODE_DISTINCT,
		MODE_INDEP,
		MODE_YEARLY
	} spread_mode_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [3:0][CFG_DATA_W-1:0] prob_word;
		logic [ENT_W-1:0]           prob_entries;
		logic [AGE_W-1:0]           first_age;
		logic [AGE_W-1:0]           last_age;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic               operation;
		logic [COUNT_W-1:0] count;
		logic [WORD_W-1:0]  word;
	} item_t;

endpackage

[rtl/rfsa_cfg.sv]
// ----------------------------------------------------------------------------
// rfsa_cfg
// APB-style register file holding the probability table, the table size and
// the age range.
// ----------------------------------------------------------------------------
module rfsa_cfg import rfsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [3:0][CFG_DATA_W-1:0] prob_q;
	logic [ENT_W-1:0]           entries_q;
	logic [AGE_W-1:0]           first_q;
	logic [AGE_W-1:0]           last_q;
	logic                       wr_en;
	reg_idx_t                   reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q    <= '0;
			entries_q <= ENT_W'(NUM_PROBS);
			first_q   <= AGE_W'(1);
			last_q    <= AGE_W'(63);
		end else if (wr_en) begin
			case (reg_sel)
				REG_PROB0:     prob_q[0] <= pwdata;
				REG_PROB1:     prob_q[1] <= pwdata;
				REG_PROB2:     prob_q[2] <= pwdata;
				REG_PROB3:     prob_q[3] <= pwdata;
				REG_ENTRIES:   entries_q <= pwdata[ENT_W-1:0];
				REG_FIRST_AGE: first_q   <= pwdata[AGE_W-1:0];
				REG_LAST_AGE:  last_q    <= pwdata[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_sel)
			REG_PROB0:     prdata = prob_q[0];
			REG_PROB1:     prdata = prob_q[1];
			REG_PROB2:     prdata = prob_q[2];
			REG_PROB3:     prdata = prob_q[3];
			REG_ENTRIES:   prdata = CFG_DATA_W'(entries_q);
			REG_FIRST_AGE: prdata = CFG_DATA_W'(first_q);
			REG_LAST_AGE:  prdata = CFG_DATA_W'(last_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.prob_word    = prob_q;
	assign cfg.prob_entries = entries_q;
	assign cfg.first_age    = first_q;
	assign cfg.last_age     = last_q;

endmodule

[rtl/rfsa_front.sv]
// ----------------------------------------------------------------------------
// rfsa_front
// Accepts items, classifies them and resolves the child count of a toss
// against the running sums of the probability table.
// ----------------------------------------------------------------------------
module rfsa_front import rfsa_pkg::*; #(
	parameter int MAX_CHILDREN = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [WORD_W-1:0] random_word,
	input  cfg_t              cfg,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	localparam int ENT_MAX = MAX_CHILDREN + 1;

	logic [SUM_W-1:0]   lvl [0:4][0:NUM_PROBS-1];
	logic [SUM_W-1:0]   sums_q [NUM_PROBS];
	logic [ENT_W-1:0]   ent_eff;
	logic               adv;
	logic               valid_s1;
	logic               op_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               valid_s2;
	logic               op_s2;
	logic [WORD_W-1:0]  word_s2;
	logic [ENT_W-1:0]   ent_s2;
	logic [NUM_PROBS-1:0] hit;
	logic [COUNT_W-1:0] count_d;

	// running sums of the table, parallel prefix over four levels
	always_comb begin
		for (int c = 0; c < NUM_PROBS; c++) begin
			lvl[0][c] = SUM_W'(cfg.prob_word[c >> 2][(c & 3) * PROB_W +: PROB_W]);
		end
		for (int l = 0; l < 4; l++) begin
			for (int c = 0; c < NUM_PROBS; c++) begin
				if (c >= (1 << l)) begin
					lvl[l+1][c] = lvl[l][c] + lvl[l][c - (1 << l)];
				end else begin
					lvl[l+1][c] = lvl[l][c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_PROBS; c++) begin
			sums_q[c] <= lvl[4][c];
		end
	end

	// table entries in use
	assign ent_eff = (cfg.prob_entries > ENT_W'(ENT_MAX)) ? ENT_W'(ENT_MAX)
		: cfg.prob_entries;

	// flow control
	assign adv      = !valid_s2 || !q_full;
	assign in_ready = !valid_s1 || adv;
	assign push     = valid_s2 && !q_full;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			op_s1   <= operation;
			word_s1 <= random_word;
		end
	end

	// classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			word_s2 <= word_s1;
			ent_s2  <= ent_eff;
		end
	end

	// first count whose running sum lies above the coin
	always_comb begin
		count_d = '0;
		for (int c = 0; c < NUM_PROBS; c++) begin
			hit[c] = (ENT_W'(c) < ent_s2) && (SUM_W'(word_s2) < sums_q[c]);
		end
		for (int c = NUM_PROBS - 1; c >= 0; c--) begin
			if (hit[c]) begin
				count_d = COUNT_W'(c);
			end
		end
	end

	assign push_item.operation = op_s2;
	assign push_item.count     = (op_s2 == OP_TOSS) ? count_d : '0;
	assign push_item.word      = word_s2;

endmodule

[rtl/rfsa_queue.sv]
// ----------------------------------------------------------------------------
// rfsa_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rfsa_queue import rfsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;
	assign head       = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/rfsa_back.sv]
// ----------------------------------------------------------------------------
// rfsa_back
// Carries out tosses and picks: family state, age slot store with shuffle
// write-back, and the output register.
// ----------------------------------------------------------------------------
module rfsa_back import rfsa_pkg::*; #(
	parameter int AGE_SLOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               head_valid,
	input  item_t              head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [COUNT_W-1:0] child_count,
	output logic [AGE_W-1:0]   child_age,
	output logic               last_child,
	output logic               misuse
);

	localparam int SLOT_W   = $clog2(AGE_SLOTS);
	localparam int SLOT_MAX = AGE_SLOTS - 1;
	localparam int KA_W     = N_W + 1;

	// family state
	logic [COUNT_W-1:0]  pending_q;
	logic [COUNT_W-1:0]  picks_q;
	spread_mode_t        mode_q;
	logic [AGE_SLOTS-1:0] written_q;

	// slot store
	logic [AGE_W-1:0]    slot_mem [AGE_SLOTS];

	// execute stage signals
	logic                adv;
	logic                take;
	logic                is_toss;
	logic [AGE_W-1:0]    hi_age;
	logic [N_W-1:0]      n_raw;
	logic [N_W-1:0]      n_ages;
	logic [N_W-1:0]      k_ext;
	logic [N_W-1:0]      span;
	logic [N_W-1:0]      mul_span;
	logic [MUL_W-1:0]    prod;
	logic [N_W-1:0]      scale;
	logic [KA_W-1:0]     ka_raw;
	logic [SLOT_W-1:0]   ka;
	logic [SLOT_W-1:0]   kk;
	logic [N_W-1:0]      cnt_ext;
	spread_mode_t        new_mode;
	logic                kind_d;
	logic [COUNT_W-1:0]  count_d;
	logic [AGE_W-1:0]    age_d;
	logic                last_d;
	logic                misuse_d;
	logic                need_mem_d;

	// slot stage registers
	logic                valid_s1;
	logic                kind_s1;
	logic [COUNT_W-1:0]  count_s1;
	logic [AGE_W-1:0]    age_s1;
	logic                last_s1;
	logic                misuse_s1;
	logic                need_mem_s1;
	logic [SLOT_W-1:0]   ka_s1;
	logic [SLOT_W-1:0]   kk_s1;
	logic [AGE_W-1:0]    rd_ka_s1;
	logic [AGE_W-1:0]    rd_kk_s1;

	// last write, for read-during-write forwarding
	logic                lw_valid_q;
	logic [SLOT_W-1:0]   lw_addr_q;
	logic [AGE_W-1:0]    lw_data_q;

	// slot stage logic
	logic [AGE_W-1:0]    data_ka;
	logic [AGE_W-1:0]    data_kk;
	logic [AGE_W-1:0]    val_ka;
	logic [AGE_W-1:0]    val_kk;
	logic                we;

	// output register
	logic                out_valid_q;
	logic                kind_q;
	logic [COUNT_W-1:0]  count_q;
	logic [AGE_W-1:0]    age_q;
	logic                last_q;
	logic                misuse_q;

	assign adv     = !out_valid_q || out_ready;
	assign take    = head_valid && adv;
	assign pop     = take;
	assign is_toss = (head.operation == OP_TOSS);

	// number of ages in range, last below first counts as one age
	assign hi_age = (cfg.last_age < cfg.first_age) ? cfg.first_age : cfg.last_age;
	assign n_raw  = N_W'(hi_age) - N_W'(cfg.first_age) + N_W'(1);
	assign n_ages = (n_raw > N_W'(AGE_SLOTS)) ? N_W'(AGE_SLOTS) : n_raw;

	// draw scaling, one shared multiplier
	assign k_ext    = N_W'(picks_q);
	assign span     = (n_ages > k_ext) ? (n_ages - k_ext) : N_W'(1);
	assign mul_span = (mode_q == MODE_DISTINCT) ? span : n_ages;
	assign prod     = MUL_W'(head.word) * MUL_W'(mul_span);
	assign scale    = prod[MUL_W-1:WORD_W];

	// shuffle slot indexes, saturated to the store
	assign ka_raw = KA_W'(picks_q) + KA_W'(scale);
	assign ka     = (ka_raw > KA_W'(SLOT_MAX)) ? SLOT_W'(SLOT_MAX) : ka_raw[SLOT_W-1:0];
	assign kk     = (KA_W'(picks_q) > KA_W'(SLOT_MAX)) ? SLOT_W'(SLOT_MAX)
		: SLOT_W'(picks_q);

	// spread mode of a new family
	assign cnt_ext = N_W'(head.count);
	always_comb begin
		if (cnt_ext < n_ages) begin
			new_mode = MODE_DISTINCT;
		end else if (cnt_ext > n_ages) begin
			new_mode = MODE_INDEP;
		end else begin
			new_mode = MODE_YEARLY;
		end
	end

	// result of the item at the queue head
	always_comb begin
		kind_d     = KIND_AGE;
		count_d    = '0;
		age_d      = '0;
		last_d     = 1'b0;
		misuse_d   = 1'b0;
		need_mem_d = 1'b0;
		if (is_toss) begin
			kind_d  = KIND_COUNT;
			count_d = head.count;
			last_d  = (head.count == '0);
		end else if (pending_q == '0) begin
			misuse_d = 1'b1;
		end else begin
			last_d = (pending_q == COUNT_W'(1));
			case (mode_q)
				MODE_DISTINCT: need_mem_d = 1'b1;
				MODE_INDEP:    age_d = cfg.first_age + scale[AGE_W-1:0];
				default:       age_d = cfg.first_age + AGE_W'(picks_q);
			endcase
		end
	end

	// family state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			picks_q   <= '0;
			mode_q    <= MODE_DISTINCT;
		end else if (take) begin
			if (is_toss) begin
				pending_q <= head.count;
				picks_q   <= '0;
				mode_q    <= new_mode;
			end else if (pending_q != '0) begin
				pending_q <= pending_q - COUNT_W'(1);
				picks_q   <= picks_q + COUNT_W'(1);
			end
		end
	end

	// slot stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1     <= kind_d;
			count_s1    <= count_d;
			age_s1      <= age_d;
			last_s1     <= last_d;
			misuse_s1   <= misuse_d;
			need_mem_s1 <= need_mem_d;
			ka_s1       <= ka;
			kk_s1       <= kk;
		end
	end

	// slot store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[ka_s1] <= val_kk;
		end
		if (take) begin
			rd_ka_s1 <= slot_mem[ka];
			rd_kk_s1 <= slot_mem[kk];
		end
	end

	// slot values with forwarding; untouched slots hold their own age
	assign data_ka = (lw_valid_q && (lw_addr_q == ka_s1)) ? lw_data_q : rd_ka_s1;
	assign data_kk = (lw_valid_q && (lw_addr_q == kk_s1)) ? lw_data_q : rd_kk_s1;
	assign val_ka  = written_q[ka_s1] ? data_ka : (cfg.first_age + AGE_W'(ka_s1));
	assign val_kk  = written_q[kk_s1] ? data_kk : (cfg.first_age + AGE_W'(kk_s1));
	assign we      = adv && valid_s1 && need_mem_s1 && (ka_s1 != kk_s1);

	// written flags, a new family clears them all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (take && is_toss) begin
			written_q <= '0;
		end else if (we) begin
			written_q[ka_s1] <= 1'b1;
		end
	end

	// last write tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (adv) begin
			lw_valid_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lw_addr_q <= ka_s1;
			lw_data_q <= val_kk;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			kind_q   <= kind_s1;
			count_q  <= count_s1;
			age_q    <= need_mem_s1 ? val_ka : age_s1;
			last_q   <= last_s1;
			misuse_q <= misuse_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign child_count = count_q;
	assign child_age   = age_q;
	assign last_child  = last_q;
	assign misuse      = misuse_q;

endmodule

[rtl/random_family_size_and_ages.sv]
// ----------------------------------------------------------------------------
// random_family_size_and_ages
// Samples a family size from a configured table and then the age of each
// child, distinct, independent or one per year.
// ----------------------------------------------------------------------------
// Usage:
//   An input item is accepted when in_valid and in_ready are both high.
//   operation selects a toss (new child count from a Q0.16 coin) or a pick
//   (age of the next child from a 16-bit draw). Every item gives exactly one
//   result item on out_valid/out_ready, in order.
//   From acceptance to out_valid an item passes the input register, count
//   compare, queue, slot store read and output register. Throughput is one
//   item per cycle while out_ready stays high; the slot store's one write port
//   and its forwarding path let a pick read what the pick before it just wrote.
//   The APB port writes the table and age range; pready is always high.
//   Reset restores the default configuration and empties the family state;
//   the slot store needs no clearing pass, per-slot written flags clear at
//   once. When out_ready is low the result holds, the back end halts, the
//   four-entry queue fills and then in_ready drops.
// ----------------------------------------------------------------------------
module random_family_size_and_ages import rfsa_pkg::*; #(
	parameter int MAX_CHILDREN = 15,
	parameter int AGE_SLOTS    = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [WORD_W-1:0]     random_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic [COUNT_W-1:0]    child_count,
	output logic [AGE_W-1:0]      child_age,
	output logic                  last_child,
	output logic                  misuse,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t  cfg;
	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head;

	// configuration registers
	rfsa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// accept and classify
	rfsa_front #(
		.MAX_CHILDREN (MAX_CHILDREN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.random_word (random_word),
		.cfg         (cfg),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	// decoupling queue
	rfsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// execute
	rfsa_back #(
		.AGE_SLOTS (AGE_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.child_count (child_count),
		.child_age   (child_age),
		.last_child  (last_child),
		.misuse      (misuse)
	);

endmodule

[rtl/rfsa_checker.sv]
// ----------------------------------------------------------------------------
// rfsa_checker
// Port-level checks of the family sampler, bound to the top level.
// ----------------------------------------------------------------------------
module rfsa_checker import rfsa_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  operation,
	input logic [WORD_W-1:0]     random_word,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  result_kind,
	input logic [COUNT_W-1:0]    child_count,
	input logic [AGE_W-1:0]      child_age,
	input logic                  last_child,
	input logic                  misuse,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	input logic [CFG_DATA_W-1:0] prdata,
	input logic                  pready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// count results: last only for an empty family, no age, no misuse
	a_count_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_COUNT) |->
			!misuse && (child_age == '0) && (last_child == (child_count == '0)))
		else $error("inconsistent count result");

	// misuse is an empty age result
	a_misuse_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && misuse |->
			(result_kind == KIND_AGE) && (child_age == '0) && !last_child)
		else $error("inconsistent misuse result");

	// age results carry no count
	a_age_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_AGE) |-> (child_count == '0))
		else $error("age result carries a count");

endmodule

bind random_family_size_and_ages rfsa_checker u_rfsa_checker (.*);
